// ===== rtl/core/ma_pkg.sv =====
package ma_pkg;

    localparam int NUM_AXES   = 3;
    localparam int DIV_STEPS  = 16;
    // Pipeline layout: lane stages 0..LANE_LAST, merge stages after that.
    localparam int LANE_LAST  = 4 + DIV_STEPS;
    localparam int NUM_STAGES = LANE_LAST + 6;
    localparam int DIV_FIRST  = 3;

    localparam int DIPOLE_SCALE = 10000;
    // floor(2^40 / 625), used to divide a value below 2^31 by 625.
    localparam int RECIP_SHIFT = 40;
    localparam logic [30:0] RECIP_625 = 31'd1759218604;
    localparam logic [30:0] DIV_625 = 31'd625;

    localparam logic [16:0] MIN_FIELD_RESET  = 17'd1000;
    localparam logic [15:0] MAX_DIPOLE_RESET = 16'd2000;

    typedef logic signed [20:0] torque_in_t;
    typedef logic signed [17:0] field_t;
    typedef logic signed [16:0] dipole_t;
    typedef logic signed [21:0] torque_out_t;
    typedef logic [15:0] limit_t;
    typedef logic [35:0] field_sq_t;
    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_WEAK    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_MIN_FIELD    = 2'd0,
        REG_MAX_DIPOLE_X = 2'd1,
        REG_MAX_DIPOLE_Y = 2'd2,
        REG_MAX_DIPOLE_Z = 2'd3
    } reg_idx_t;

endpackage

// ===== rtl/core/ma_req_if.sv =====
interface ma_req_if;
    logic                  valid;
    logic                  ready;
    ma_pkg::torque_in_t    torque_req_x;
    ma_pkg::torque_in_t    torque_req_y;
    ma_pkg::torque_in_t    torque_req_z;
    ma_pkg::field_t        field_x;
    ma_pkg::field_t        field_y;
    ma_pkg::field_t        field_z;

    modport source (output valid, torque_req_x, torque_req_y, torque_req_z,
                    field_x, field_y, field_z, input ready);
    modport sink (input valid, torque_req_x, torque_req_y, torque_req_z,
                  field_x, field_y, field_z, output ready);
endinterface

// ===== rtl/core/ma_rsp_if.sv =====
interface ma_rsp_if;
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic                   enabled;
    ma_pkg::dipole_t        dipole_x;
    ma_pkg::dipole_t        dipole_y;
    ma_pkg::dipole_t        dipole_z;
    ma_pkg::torque_out_t    torque_out_x;
    ma_pkg::torque_out_t    torque_out_y;
    ma_pkg::torque_out_t    torque_out_z;
    logic                   saturated;

    modport source (output valid, status, enabled, dipole_x, dipole_y, dipole_z,
                    torque_out_x, torque_out_y, torque_out_z, saturated,
                    input ready);
    modport sink (input valid, status, enabled, dipole_x, dipole_y, dipole_z,
                  torque_out_x, torque_out_y, torque_out_z, saturated,
                  output ready);
endinterface

// ===== rtl/core/ma_lane.sv =====
module ma_lane (
    input  logic                  clk,
    input  ma_pkg::stage_en_t     adv,
    input  ma_pkg::field_t        ba,
    input  ma_pkg::torque_in_t    tb,
    input  ma_pkg::field_t        bb,
    input  ma_pkg::torque_in_t    ta,
    input  ma_pkg::field_sq_t     b2,
    input  ma_pkg::limit_t        lim,
    output ma_pkg::dipole_t       dipole,
    output logic                  sat
);

    localparam int NS = ma_pkg::DIV_STEPS;
    localparam int DF = ma_pkg::DIV_FIRST;

    logic signed [38:0] p1_reg, p2_reg;
    logic signed [39:0] c_reg;
    logic [52:0]        n_reg;
    logic               neg2_reg;
    ma_pkg::field_sq_t  den2_reg;

    logic [52:0]        rem_reg [0:NS-1];
    ma_pkg::field_sq_t  den_reg [0:NS-1];
    logic [NS-1:0]      q_reg   [0:NS];
    logic               neg_reg [0:NS];
    logic               ovf_reg [0:NS];

    ma_pkg::dipole_t    dipole_reg;
    logic               sat_reg;

    logic [38:0]        c_mag;

    assign c_mag = c_reg[39] ? 39'(-c_reg) : c_reg[38:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p1_reg <= 39'(ba * tb);
            p2_reg <= 39'(bb * ta);
        end
        if (adv[1])
        begin
            c_reg <= 40'(p1_reg) - 40'(p2_reg);
        end
        if (adv[2])
        begin
            n_reg    <= 53'(c_mag) * 53'(ma_pkg::DIPOLE_SCALE);
            neg2_reg <= c_reg[39];
            den2_reg <= b2;
        end
        if (adv[DF])
        begin
            // A quotient of 2^16 or more is above any limit.
            ovf_reg[0] <= n_reg >= {1'b0, den2_reg, 16'd0};
            rem_reg[0] <= n_reg;
            den_reg[0] <= den2_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg2_reg;
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        logic [52:0] den_sh;
        logic        fits;

        assign den_sh = 53'(den_reg[j]) << (NS - 1 - j);
        assign fits   = rem_reg[j] >= den_sh;

        always_ff @(posedge clk)
        begin
            if (adv[DF + 1 + j])
            begin
                q_reg[j+1]   <= q_reg[j] | (NS'(fits) << (NS - 1 - j));
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end

        // The last step only needs its quotient bit, not the remainder.
        if (j < NS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv[DF + 1 + j])
                begin
                    rem_reg[j+1] <= fits ? rem_reg[j] - den_sh : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    logic                clip;
    logic [15:0]         mag;

    assign clip = ovf_reg[NS] || (q_reg[NS] > lim);
    assign mag  = clip ? lim : q_reg[NS];

    always_ff @(posedge clk)
    begin
        if (adv[ma_pkg::LANE_LAST])
        begin
            dipole_reg <= neg_reg[NS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            sat_reg    <= clip;
        end
    end

    assign dipole = dipole_reg;
    assign sat    = sat_reg;

endmodule

// ===== rtl/core/ma_merge.sv =====
module ma_merge (
    input  logic                       clk,
    input  ma_pkg::stage_en_t          adv,
    input  ma_pkg::dipole_t            d_in [ma_pkg::NUM_AXES],
    input  logic [ma_pkg::NUM_AXES-1:0] sat_in,
    input  ma_pkg::field_t             b_in [ma_pkg::NUM_AXES],
    input  ma_pkg::status_t            status_in,
    output ma_pkg::status_t            status,
    output logic                       enabled,
    output ma_pkg::dipole_t            dipole [ma_pkg::NUM_AXES],
    output ma_pkg::torque_out_t        torque [ma_pkg::NUM_AXES],
    output logic                       saturated
);

    localparam int NA = ma_pkg::NUM_AXES;
    localparam int S1 = ma_pkg::LANE_LAST + 1;

    logic signed [34:0] p1_reg [NA], p2_reg [NA];
    logic [30:0]        y_reg  [NA];
    logic [30:0]        y3_reg [NA];
    logic [30:0]        y4_reg [NA];
    logic [61:0]        prod_reg [NA];
    logic [21:0]        q0_reg [NA];
    logic [30:0]        t_reg  [NA];
    logic               neg_reg [1:3][NA];

    ma_pkg::dipole_t    d_reg  [4][NA];
    logic               sat_reg [4];
    ma_pkg::status_t    st_reg  [4];

    ma_pkg::status_t    status_reg;
    ma_pkg::dipole_t    dipole_reg [NA];
    ma_pkg::torque_out_t torque_reg [NA];
    logic               saturated_reg;

    always_ff @(posedge clk)
    begin
        if (adv[S1])
        begin
            for (int k = 0; k < NA; k++)
            begin
                p1_reg[k] <= 35'(d_in[(k+1)%NA] * b_in[(k+2)%NA]);
                p2_reg[k] <= 35'(d_in[(k+2)%NA] * b_in[(k+1)%NA]);
                d_reg[0][k] <= d_in[k];
            end
            sat_reg[0] <= |sat_in;
            st_reg[0]  <= status_in;
        end
        if (adv[S1 + 1])
        begin
            for (int k = 0; k < NA; k++)
            begin
                logic signed [35:0] x;
                logic [35:0]        xm;
                x  = 36'(p1_reg[k]) - 36'(p2_reg[k]);
                xm = x[35] ? 36'(-x) : 36'(x);
                // Dividing by 16 first leaves a division by 625.
                y_reg[k]      <= xm[34:4];
                neg_reg[1][k] <= x[35];
                d_reg[1][k]   <= d_reg[0][k];
            end
            sat_reg[1] <= sat_reg[0];
            st_reg[1]  <= st_reg[0];
        end
        if (adv[S1 + 2])
        begin
            for (int k = 0; k < NA; k++)
            begin
                prod_reg[k]   <= 62'(y_reg[k]) * 62'(ma_pkg::RECIP_625);
                y3_reg[k]     <= y_reg[k];
                neg_reg[2][k] <= neg_reg[1][k];
                d_reg[2][k]   <= d_reg[1][k];
            end
            sat_reg[2] <= sat_reg[1];
            st_reg[2]  <= st_reg[1];
        end
        if (adv[S1 + 3])
        begin
            for (int k = 0; k < NA; k++)
            begin
                logic [21:0] q0;
                q0 = prod_reg[k][ma_pkg::RECIP_SHIFT +: 22];
                q0_reg[k]     <= q0;
                t_reg[k]      <= 31'(31'(q0) * ma_pkg::DIV_625);
                y4_reg[k]     <= y3_reg[k];
                neg_reg[3][k] <= neg_reg[2][k];
                d_reg[3][k]   <= d_reg[2][k];
            end
            sat_reg[3] <= sat_reg[2];
            st_reg[3]  <= st_reg[2];
        end
        if (adv[S1 + 4])
        begin
            for (int k = 0; k < NA; k++)
            begin
                logic [30:0] r;
                logic [21:0] q;
                // The reciprocal estimate is low by at most one.
                r = y4_reg[k] - t_reg[k];
                q = (r >= ma_pkg::DIV_625) ? q0_reg[k] + 22'd1 : q0_reg[k];
                if (st_reg[3] == ma_pkg::ST_OK)
                begin
                    dipole_reg[k] <= d_reg[3][k];
                    torque_reg[k] <= neg_reg[3][k] ? -$signed(q) : $signed(q);
                end
                else
                begin
                    dipole_reg[k] <= '0;
                    torque_reg[k] <= '0;
                end
            end
            status_reg    <= st_reg[3];
            saturated_reg <= (st_reg[3] == ma_pkg::ST_OK) && sat_reg[3];
        end
    end

    assign status    = status_reg;
    assign enabled   = (status_reg == ma_pkg::ST_OK);
    assign dipole    = dipole_reg;
    assign torque    = torque_reg;
    assign saturated = saturated_reg;

endmodule

// ===== rtl/core/magnetorquer_dipole_allocator.sv =====
// Magnetorquer dipole allocator.
// Requests arrive on req (torque request and field vector) with a valid/ready
// handshake; each accepted request yields exactly one result on rsp, in order.
// Three axis lanes each form one cross-product component, scale it and divide
// it by |B|^2 in a 16-step restoring divider, one quotient bit per stage, then
// clamp it to the axis limit. The merge stages form the achievable torque m x B
// and divides it by 10000 with a reciprocal multiply and one correction.
// One request per cycle is sustained while rsp is taken, set by the pipelined
// divider of each lane.
// Every stage keeps its own valid bit and moves up whenever the stage after it
// is empty or moving, so when the receiver stalls, bubbles collapse and requests
// are still taken until the pipeline is full; rsp holds steady until taken.
// Reset empties the pipeline and loads the limit registers with their defaults.
// The user must write registers over the APB port only while no request is in
// flight; the block does not enforce it. min_field 0x0, max_dipole_x/y/z 0x4/8/C.
module magnetorquer_dipole_allocator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    ma_req_if.sink       req,
    ma_rsp_if.source     rsp
);

    localparam int NA = ma_pkg::NUM_AXES;
    localparam int NS = ma_pkg::NUM_STAGES;
    localparam int LL = ma_pkg::LANE_LAST;

    logic [16:0]          min_field_reg;
    ma_pkg::limit_t       lim_reg [NA];
    logic [33:0]          mn2_reg;
    ma_pkg::reg_idx_t     idx;

    assign pready = 1'b1;
    assign idx    = ma_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_field_reg <= ma_pkg::MIN_FIELD_RESET;
            for (int k = 0; k < NA; k++)
            begin
                lim_reg[k] <= ma_pkg::MAX_DIPOLE_RESET;
            end
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                ma_pkg::REG_MIN_FIELD:    min_field_reg <= pwdata[16:0];
                ma_pkg::REG_MAX_DIPOLE_X: lim_reg[0]    <= pwdata[15:0];
                ma_pkg::REG_MAX_DIPOLE_Y: lim_reg[1]    <= pwdata[15:0];
                ma_pkg::REG_MAX_DIPOLE_Z: lim_reg[2]    <= pwdata[15:0];
                default:                  min_field_reg <= min_field_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ma_pkg::REG_MIN_FIELD:    prdata = 32'(min_field_reg);
            ma_pkg::REG_MAX_DIPOLE_X: prdata = 32'(lim_reg[0]);
            ma_pkg::REG_MAX_DIPOLE_Y: prdata = 32'(lim_reg[1]);
            ma_pkg::REG_MAX_DIPOLE_Z: prdata = 32'(lim_reg[2]);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mn2_reg <= 34'(min_field_reg) * 34'(min_field_reg);
    end

    // Stage handshake: a stage loads when it is empty or its content moves on.
    logic [NS-1:0]       valid_reg;
    ma_pkg::stage_en_t   adv;

    always_comb
    begin
        adv[NS-1] = !valid_reg[NS-1] || rsp.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= (i == 0) ? req.valid : valid_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign req.ready = adv[0];
    assign rsp.valid = valid_reg[NS-1];

    // Field vector and status travel beside the lanes to the merge stage.
    ma_pkg::field_t      b_reg [0:LL][NA];
    ma_pkg::field_sq_t   sq_reg [NA];
    ma_pkg::field_sq_t   b2_reg;
    ma_pkg::status_t     st_reg [2:LL];

    ma_pkg::field_t      b_in [NA];
    ma_pkg::torque_in_t  t_in [NA];

    assign b_in[0] = req.field_x;
    assign b_in[1] = req.field_y;
    assign b_in[2] = req.field_z;
    assign t_in[0] = req.torque_req_x;
    assign t_in[1] = req.torque_req_y;
    assign t_in[2] = req.torque_req_z;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < NA; k++)
            begin
                b_reg[0][k] <= b_in[k];
                sq_reg[k]   <= 36'(b_in[k] * b_in[k]);
            end
        end
        if (adv[1])
        begin
            b2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
        if (adv[2])
        begin
            // A weak field is reported ahead of a zero axis limit.
            priority if (min_field_reg == '0)
                st_reg[2] <= ma_pkg::ST_INVALID;
            else if (b2_reg < 36'(mn2_reg))
                st_reg[2] <= ma_pkg::ST_WEAK;
            else if (lim_reg[0] == '0 || lim_reg[1] == '0 || lim_reg[2] == '0)
                st_reg[2] <= ma_pkg::ST_INVALID;
            else
                st_reg[2] <= ma_pkg::ST_OK;
        end
    end

    for (genvar i = 1; i <= LL; i++)
    begin : g_bpipe
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                b_reg[i] <= b_reg[i-1];
            end
        end
    end

    for (genvar i = 3; i <= LL; i++)
    begin : g_stpipe
        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                st_reg[i] <= st_reg[i-1];
            end
        end
    end

    ma_pkg::dipole_t     d_lane [NA];
    logic [NA-1:0]       sat_lane;

    for (genvar k = 0; k < NA; k++)
    begin : g_lane
        ma_lane u_lane (
            .clk    (clk),
            .adv    (adv),
            .ba     (b_in[(k+1)%NA]),
            .tb     (t_in[(k+2)%NA]),
            .bb     (b_in[(k+2)%NA]),
            .ta     (t_in[(k+1)%NA]),
            .b2     (b2_reg),
            .lim    (lim_reg[k]),
            .dipole (d_lane[k]),
            .sat    (sat_lane[k])
        );
    end

    ma_pkg::status_t     status;
    ma_pkg::dipole_t     dipole [NA];
    ma_pkg::torque_out_t torque [NA];

    ma_merge u_merge (
        .clk       (clk),
        .adv       (adv),
        .d_in      (d_lane),
        .sat_in    (sat_lane),
        .b_in      (b_reg[LL]),
        .status_in (st_reg[LL]),
        .status    (status),
        .enabled   (rsp.enabled),
        .dipole    (dipole),
        .torque    (torque),
        .saturated (rsp.saturated)
    );

    assign rsp.status       = status;
    assign rsp.dipole_x     = dipole[0];
    assign rsp.dipole_y     = dipole[1];
    assign rsp.dipole_z     = dipole[2];
    assign rsp.torque_out_x = torque[0];
    assign rsp.torque_out_y = torque[1];
    assign rsp.torque_out_z = torque[2];

endmodule
